@@ sv/ipfrag_pkg.sv @@
package ipfrag_pkg;

    // Reset values and fixed limits
    localparam logic [15:0] MTU_RESET     = 16'd1500;
    localparam logic [15:0] MTU_FLOOR     = 16'd1088;
    localparam int          MAX_PACKET_DEF = 65535;
    localparam int          MAX_FRAGS     = 64;
    localparam int          FRAG_CNT_W    = $clog2(MAX_FRAGS);
    localparam int          BLOCK_SHIFT   = 3;   // 8-byte blocks
    localparam int          WORD_SHIFT    = 2;   // 4-byte header words

    // Result status codes
    localparam logic [1:0] ST_WHOLE    = 2'd0;
    localparam logic [1:0] ST_FRAG     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    // Packed widths of the stream words
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic load;      // latch a new datagram descriptor
        logic classify;  // decide the result kind and fragment size
        logic emit;      // write one result word to the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;       // status code of the current datagram
        logic       frag_done;  // the word emitted now is the last one
    } dp_status_t;

endpackage

@@ sv/ipfrag_dp.sv @@
module ipfrag_dp #(
    parameter int MAX_PACKET = ipfrag_pkg::MAX_PACKET_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ipfrag_pkg::ctrl_cmd_t            cmd,
    output ipfrag_pkg::dp_status_t           sts,
    input  logic                             cfg_we,
    input  logic [15:0]                      cfg_data,
    input  logic [ipfrag_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [ipfrag_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    localparam int CW = ipfrag_pkg::FRAG_CNT_W;

    logic [15:0] mtu_eff_reg, mtu_eff_next;
    logic [15:0] ident_ctr_reg, ident_ctr_next;
    logic [15:0] ident_reg;
    logic [15:0] payload_reg;
    logic [5:0]  hbytes_reg;
    logic        df_reg;
    logic [16:0] total_reg;
    logic [1:0]  kind_reg;
    logic [12:0] blks_reg;
    logic [15:0] fsize_reg;
    logic [15:0] len_reg;
    logic [12:0] off_reg;
    logic [CW-1:0] cnt_reg;

    logic [15:0] in_payload;
    logic [5:0]  in_hbytes;
    logic [15:0] room;
    logic [1:0]  kind_next;
    logic [15:0] chunk;
    logic        more;
    logic [15:0] o_total;
    logic [15:0] o_chunk;
    logic [12:0] o_off;
    logic        o_mf;
    logic        o_df;
    logic        o_last;

    assign in_payload = s_tdata[15:0];
    assign in_hbytes  = {s_tdata[19:16], 2'b00};

    // Keep the floored MTU so the compare path stays short
    assign mtu_eff_next = (cfg_data < ipfrag_pkg::MTU_FLOOR) ? ipfrag_pkg::MTU_FLOOR : cfg_data;
    assign ident_ctr_next = ident_ctr_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_eff_reg   <= ipfrag_pkg::MTU_RESET;
            ident_ctr_reg <= 16'd1;
        end else begin
            if (cfg_we) begin
                mtu_eff_reg <= mtu_eff_next;
            end
            if (cmd.load) begin
                ident_ctr_reg <= ident_ctr_next;
            end
        end
    end

    // Classification
    assign room = mtu_eff_reg - {10'd0, hbytes_reg};

    always_comb begin
        if (total_reg > 17'(MAX_PACKET)) begin
            kind_next = ipfrag_pkg::ST_TOO_LONG;
        end else if (total_reg <= {1'b0, mtu_eff_reg}) begin
            kind_next = ipfrag_pkg::ST_WHOLE;
        end else if (df_reg) begin
            kind_next = ipfrag_pkg::ST_DROPPED;
        end else begin
            kind_next = ipfrag_pkg::ST_FRAG;
        end
    end

    // Fragment step
    assign chunk = (len_reg > fsize_reg) ? fsize_reg : len_reg;
    assign more  = (chunk != len_reg);

    always_comb begin
        o_total = 16'd0;
        o_chunk = 16'd0;
        o_off   = 13'd0;
        o_mf    = 1'b0;
        o_df    = 1'b0;
        o_last  = 1'b1;
        case (kind_reg)
            ipfrag_pkg::ST_WHOLE: begin
                o_total = total_reg[15:0];
                o_chunk = payload_reg;
                o_df    = df_reg;
            end
            ipfrag_pkg::ST_FRAG: begin
                o_total = chunk + {10'd0, hbytes_reg};
                o_chunk = chunk;
                o_off   = off_reg;
                o_mf    = more;
                o_last  = !more;
            end
            ipfrag_pkg::ST_DROPPED: begin
                o_total = total_reg[15:0];
            end
            default: begin
                o_total = 16'd0;
            end
        endcase
    end

    assign sts.kind      = kind_reg;
    assign sts.frag_done = (kind_reg != ipfrag_pkg::ST_FRAG) || !more
                           || (cnt_reg == CW'(ipfrag_pkg::MAX_FRAGS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            payload_reg <= in_payload;
            hbytes_reg  <= in_hbytes;
            df_reg      <= s_tdata[20];
            ident_reg   <= ident_ctr_reg;
            total_reg   <= {1'b0, in_payload} + {11'd0, in_hbytes};
        end
        if (cmd.classify) begin
            kind_reg  <= kind_next;
            blks_reg  <= room[15:ipfrag_pkg::BLOCK_SHIFT];
            fsize_reg <= {room[15:ipfrag_pkg::BLOCK_SHIFT], 3'b000};
            len_reg   <= payload_reg;
            off_reg   <= 13'd0;
            cnt_reg   <= '0;
        end
        if (cmd.emit) begin
            m_tdata <= {1'b0, o_chunk, o_total, o_df, o_mf, o_off, ident_reg};
            m_tuser <= kind_reg;
            m_tlast <= o_last;
            if (kind_reg == ipfrag_pkg::ST_FRAG) begin
                len_reg <= len_reg - chunk;
                off_reg <= off_reg + blks_reg;
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

endmodule

@@ sv/ipfrag_ctrl.sv @@
module ipfrag_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output ipfrag_pkg::ctrl_cmd_t  cmd,
    input  ipfrag_pkg::dp_status_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_tready     = (state_reg == S_IDLE);
    assign m_tvalid     = m_tvalid_reg;
    assign cmd.load     = s_tvalid && s_tready;
    assign cmd.classify = (state_reg == S_CALC);
    assign cmd.emit     = (state_reg == S_EMIT) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (cmd.emit && sts.frag_done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_CALC))
        else $error("accepted word did not move to classification");

    a_single_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (sts.kind != ipfrag_pkg::ST_FRAG)) |=> (state_reg == S_IDLE))
        else $error("single-result datagram did not finish after one word");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EMIT) && !out_free) |=> (state_reg == S_EMIT))
        else $error("emit state left while output register was blocked");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted word not presented");
`endif

endmodule

@@ sv/ipv4_datagram_fragmenter.sv @@
// m_tvalid rises once a descriptor accepted at an edge has passed the classify
//   and emit states; emit waits while the output register is blocked.
// Each descriptor is loaded, classified, then emitted once per header word; a new
//   one is taken only in idle. The next descriptor is taken while the last word waits.
// Reset: synchronous, active-low aresetn; clears the controller, sets mtu to 1500
//   and the identification counter to 1.
module ipv4_datagram_fragmenter #(
    parameter int MAX_PACKET = ipfrag_pkg::MAX_PACKET_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Descriptor input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] payload_len, [19:16] header_words, [20] dont_fragment, [23:21] zero
    input  logic [ipfrag_pkg::S_TDATA_W-1:0] s_tdata,
    // Header result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] ident, [28:16] frag_offset, [29] more_fragments, [30] df_out,
    // [46:31] total_length, [62:47] chunk_bytes, [63] zero
    output logic [ipfrag_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    // MTU register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [15:0]                      cfg_data
);

    ipfrag_pkg::ctrl_cmd_t  cmd;
    ipfrag_pkg::dp_status_t sts;

    // The user must write configuration only while idle; the block does not enforce it and always takes it.
    assign cfg_ready = 1'b1;

    // Sequencer: owns both handshakes and steps the datapath.
    ipfrag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath: ident counter, classification, fragment walk, output register.
    ipfrag_dp #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/sv/tb_ipv4_datagram_fragmenter.sv @@
module tb_ipv4_datagram_fragmenter;

    // One datagram descriptor as it travels on s_tdata
    typedef struct {
        logic [15:0] payload_len;
        logic [3:0]  header_words;
        logic        dont_fragment;
    } desc_t;

    // One header result as it travels on m_tdata / m_tuser / m_tlast
    typedef struct {
        logic [1:0]  status;
        logic [15:0] ident;
        logic [12:0] frag_offset;
        logic        more_fragments;
        logic        df_out;
        logic [15:0] total_length;
        logic [15:0] chunk_bytes;
        logic        last;
    } hdr_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ipfrag_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ipfrag_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0]                       m_tuser;
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [15:0]                      cfg_data = '0;

    ipv4_datagram_fragmenter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run (every datagram at 64
    // fragments, every word behind the longest output stall).
    initial begin
        #25_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Shadow state of the fragmenter: mtu register and identification counter
    logic [15:0] mtu_shadow = ipfrag_pkg::MTU_RESET;
    logic [15:0] ident_ctr  = 16'd1;

    desc_t desc_q[$];        // descriptors waiting for the driver
    hdr_t  pending_hdrs[$];  // header words owed by the block, oldest first

    int queued_cnt   = 0;
    int accepted_cnt = 0;
    int errors       = 0;
    int hdr_seen     = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int mtu_settings = 1;

    logic desc_taken = 1'b0;  // current s_ word went through at the last rising edge
    logic calm       = 1'b0;  // suppress idling on both sides for a stretch
    int   gap_left   = 0;
    int   stall_left = 0;

    // Idle length: drawn mostly from a short range, now and then from a long one
    function automatic int pick_idle();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Work out every header word one datagram owes and queue it. The
    // counter advances on every datagram, whatever the outcome.
    function automatic void fragment_datagram(desc_t d);
        int unsigned hbytes, total, eff, blks, fsize, left, off, chunk, n;
        hdr_t h;
        hbytes = int'(d.header_words) << ipfrag_pkg::WORD_SHIFT;
        total  = 32'(d.payload_len) + hbytes;
        eff    = (mtu_shadow < ipfrag_pkg::MTU_FLOOR) ? 32'(ipfrag_pkg::MTU_FLOOR)
                                                      : 32'(mtu_shadow);
        h = '{status: ipfrag_pkg::ST_WHOLE, ident: ident_ctr, frag_offset: '0,
              more_fragments: 1'b0, df_out: 1'b0, total_length: '0, chunk_bytes: '0,
              last: 1'b1};
        ident_ctr = ident_ctr + 16'd1;
        if (total > ipfrag_pkg::MAX_PACKET_DEF) begin
            // too long: only status, ident and last carry information
            h.status = ipfrag_pkg::ST_TOO_LONG;
            pending_hdrs.push_back(h);
        end else if (total <= eff) begin
            h.df_out       = d.dont_fragment;
            h.total_length = total[15:0];
            h.chunk_bytes  = d.payload_len;
            pending_hdrs.push_back(h);
        end else if (d.dont_fragment) begin
            // needs cutting but must not be cut: drop, report its size
            h.status       = ipfrag_pkg::ST_DROPPED;
            h.total_length = total[15:0];
            pending_hdrs.push_back(h);
        end else begin
            blks  = (eff - hbytes) >> ipfrag_pkg::BLOCK_SHIFT;
            fsize = blks << ipfrag_pkg::BLOCK_SHIFT;
            left  = 32'(d.payload_len);
            off   = 0;
            n     = 0;
            while (left > 0 && n < ipfrag_pkg::MAX_FRAGS) begin
                chunk            = (left > fsize) ? fsize : left;
                h.status         = ipfrag_pkg::ST_FRAG;
                h.frag_offset    = off[12:0];
                h.more_fragments = (chunk != left);
                h.total_length   = 16'(hbytes + chunk);
                h.chunk_bytes    = chunk[15:0];
                h.last           = !h.more_fragments;
                pending_hdrs.push_back(h);
                n++;
                left -= chunk;
                off  += blks;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result word with the oldest owed header
    function automatic void check_header();
        hdr_t want;
        if (pending_hdrs.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got status %0d ident %0d",
                     $time, m_tuser, m_tdata[15:0]);
            errors++;
            return;
        end
        want = pending_hdrs.pop_front();
        hdr_seen++;
        status_tally[want.status]++;
        check_field("status",         32'(want.status),         32'(m_tuser));
        check_field("ident",          32'(want.ident),          32'(m_tdata[15:0]));
        check_field("frag_offset",    32'(want.frag_offset),    32'(m_tdata[28:16]));
        check_field("more_fragments", 32'(want.more_fragments), 32'(m_tdata[29]));
        check_field("df_out",         32'(want.df_out),         32'(m_tdata[30]));
        check_field("total_length",   32'(want.total_length),   32'(m_tdata[46:31]));
        check_field("chunk_bytes",    32'(want.chunk_bytes),    32'(m_tdata[62:47]));
        check_field("last",           32'(want.last),           32'(m_tlast));
    endfunction

    // Monitor: sample both handshakes at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            desc_taken <= 1'b0;
        end else begin
            desc_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                fragment_datagram('{payload_len: s_tdata[15:0], header_words: s_tdata[19:16],
                                    dont_fragment: s_tdata[20]});
                accepted_cnt++;
            end
            if (m_tvalid && m_tready)
                check_header();
        end
    end

    // Driver: hold a word until it is taken, then idle or present the next one
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || desc_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (desc_q.size() != 0) begin
                desc_t d;
                d = desc_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, d.dont_fragment, d.header_words, d.payload_len};
                gap_left <= (!calm && $urandom_range(0, 99) < 35) ? pick_idle() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: drop ready for random stretches
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            m_tready   <= 1'b0;
            stall_left <= pick_idle() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_datagram(input logic [15:0] payload, input logic [3:0] hw,
                                  input logic df);
        desc_q.push_back('{payload_len: payload, header_words: hw, dont_fragment: df});
        queued_cnt++;
    endtask

    // Random descriptor, weighted toward each outcome at the current mtu;
    // fragment runs mostly stay short, the fully random share reaches the long ones
    function automatic desc_t pick_datagram(int unsigned eff);
        desc_t d;
        int unsigned kind, hb, lo, hi;
        kind            = $urandom_range(0, 99);
        d.header_words  = 4'($urandom_range(0, 15));
        d.dont_fragment = 1'($urandom_range(0, 1));
        d.payload_len   = 16'($urandom_range(0, 65535));
        hb = 32'(d.header_words) * 4;
        if (kind < 30) begin
            d.payload_len = 16'($urandom_range(0, eff - hb));
        end else if (kind < 72) begin
            lo = eff - hb + 1;
            hi = 3 * eff;
            if (hi > 65535 - hb)
                hi = 65535 - hb;
            if (lo <= hi) begin
                d.payload_len   = 16'($urandom_range(lo, hi));
                d.dont_fragment = (kind >= 60);
            end
        end else if (kind < 80) begin
            if (d.header_words == 0)
                d.header_words = 4'($urandom_range(1, 15));
            hb = 32'(d.header_words) * 4;
            d.payload_len = 16'($urandom_range(65536 - hb, 65535));
        end
        return d;
    endfunction

    // Wait until every descriptor is in and every owed header has come out
    task automatic drain();
        while (accepted_cnt != queued_cnt || pending_hdrs.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_mtu(input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        mtu_shadow = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        mtu_settings++;
    endtask

    initial begin
        logic [15:0] mtu_plan [9];
        logic [15:0] mtu_next;
        int unsigned eff;
        // Reset value first, then floor, below floor, maximum and a few in between
        mtu_plan = '{16'd1500, 16'd1088, 16'd0, 16'd65535, 16'd576, 16'd1087,
                     16'd9000, 16'd1500, 16'd1500};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int p = 0; p < 9; p++) begin
            if (p > 0) begin
                drain();
                mtu_next = (p == 7) ? 16'($urandom_range(1088, 65535)) : mtu_plan[p];
                write_mtu(mtu_next);
            end
            eff  = (mtu_shadow < ipfrag_pkg::MTU_FLOOR) ? 32'(ipfrag_pkg::MTU_FLOOR)
                                                        : 32'(mtu_shadow);
            calm = ($urandom_range(0, 3) == 0);

            if (p == 0) begin
                // Directed set at the reset mtu of 1500
                queue_datagram(16'd0,     4'd5,  1'b0);  // empty payload
                queue_datagram(16'd0,     4'd0,  1'b1);  // zero header, df carried
                queue_datagram(16'd1480,  4'd5,  1'b0);  // fits mtu exactly
                queue_datagram(16'd1480,  4'd5,  1'b1);
                queue_datagram(16'd1481,  4'd5,  1'b1);  // one byte over, df set: drop
                queue_datagram(16'd1481,  4'd5,  1'b0);  // one byte over: two fragments
                queue_datagram(16'd2960,  4'd5,  1'b0);  // last fragment at full size
                queue_datagram(16'd65535, 4'd5,  1'b0);  // too long
                queue_datagram(16'd65516, 4'd5,  1'b1);  // too long wins over df
                queue_datagram(16'd65515, 4'd5,  1'b0);  // largest legal total
                queue_datagram(16'd65535, 4'd0,  1'b1);  // largest legal, dropped
                queue_datagram(16'd4000,  4'd15, 1'b0);  // longest header
                queue_datagram(16'd3000,  4'd3,  1'b0);  // short header
                queue_datagram(16'd1496,  4'd1,  1'b0);
                queue_datagram(16'hAAAA,  4'hA,  1'b1);
                queue_datagram(16'h5555,  4'h5,  1'b0);
            end
            if (mtu_shadow == 16'd0) begin
                // mtu below the floor behaves as the floor
                queue_datagram(16'd1028,  4'd15, 1'b0);  // fills the floor exactly
                queue_datagram(16'd1029,  4'd15, 1'b0);
                queue_datagram(16'd65475, 4'd15, 1'b0);  // the full 64 fragments
            end

            repeat (28) begin
                desc_q.push_back(pick_datagram(eff));
                queued_cnt++;
            end
        end

        drain();
        // allow any stray words to show up before the verdict
        repeat (8) @(posedge aclk);

        $display("Covered %0d datagrams over %0d mtu settings, %0d header words checked",
                 accepted_cnt, mtu_settings, hdr_seen);
        $display("Outcomes: whole %0d, fragments %0d, too long %0d, dropped %0d",
                 status_tally[ipfrag_pkg::ST_WHOLE], status_tally[ipfrag_pkg::ST_FRAG],
                 status_tally[ipfrag_pkg::ST_TOO_LONG], status_tally[ipfrag_pkg::ST_DROPPED]);
        if (errors == 0 && pending_hdrs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
